// ----- design/rghold_pkg.sv -----
`default_nettype none
package rghold_pkg;

	localparam int unsigned CFG_ADDR_W  = 3;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned TIME_W      = 64;
	localparam logic [31:0] HOLD_RESET  = 32'd1000;

	// Register index, taken from the top bit of paddr.
	localparam logic [0:0] REG_RECOVERY_HOLD = 1'b0;

	localparam logic [1:0] MODE_STATE_BLIND    = 2'd1;
	localparam logic [1:0] MODE_REGISTRY_BLIND = 2'd2;

	typedef enum logic [1:0] {
		ST_OK              = 2'd0,
		ST_CFG_INVALID     = 2'd1,
		ST_CLOCK_REGRESSED = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		R_READY           = 4'd0,
		R_NO_FULL         = 4'd1,
		R_NO_CAPACITY     = 4'd2,
		R_NO_OBSERVATION  = 4'd3,
		R_STATE_BLIND     = 4'd4,
		R_REGISTRY_NO_CAP = 4'd5,
		R_GRACE_EXPIRED   = 4'd6,
		R_DRAINING        = 4'd7,
		R_HOLD            = 4'd8,
		R_NOT_LEADER      = 4'd9
	} reason_t;

	typedef struct packed {
		logic              leader;
		logic              draining;
		logic              has_full_snapshot;
		logic              observation_present;
		logic [1:0]        observation_mode;
		logic              grace_open;
		logic              has_capacity;
		logic [TIME_W-1:0] now_ms;
	} sample_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              accepting;
		logic [3:0]        reason_code;
		logic [TIME_W-1:0] changed_ms;
	} result_t;

	// Unsafe reasons in priority order; R_READY when the sample is safe.
	function automatic reason_t find_unsafe(sample_t s, logic ever_ready, logic ready);
		reason_t r;
		r = R_READY;
		if (!s.leader) begin
			r = R_NOT_LEADER;
		end else if (s.draining) begin
			r = R_DRAINING;
		end else if (!s.has_full_snapshot) begin
			r = R_NO_FULL;
		end else if (!s.observation_present) begin
			r = R_NO_OBSERVATION;
		end else if (s.observation_mode == MODE_REGISTRY_BLIND && !s.grace_open) begin
			r = R_GRACE_EXPIRED;
		end else if (s.observation_mode == MODE_REGISTRY_BLIND && !s.has_capacity) begin
			r = R_REGISTRY_NO_CAP;
		end else if (s.observation_mode == MODE_STATE_BLIND && !s.has_capacity) begin
			r = R_STATE_BLIND;
		end else if (!s.has_capacity && (!ever_ready || !ready)) begin
			r = R_NO_CAPACITY;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- design/readiness_gate_hold_timer.sv -----
// Channel  Payload            Handshake                    Direction
// sample   rghold_pkg sample  sample_valid / sample_stall  in
// result   rghold_pkg result  result_valid / result_stall  out
// config   APB register 0     psel/penable/pwrite/pready   in
//
// One sample is taken every cycle while sample_stall is low; each gives exactly one result word.
// A sample passes through an input register, then the gate logic (a priority
// check and one 64-bit subtract and compare) writes the result register.
// The state update happens in the same cycle, so back-to-back samples see it.
// Reset inits control state, not data; the hold register comes up at 1000 ms.
// A stalled result holds both stages; sample_stall rises only then.
`default_nettype none
module readiness_gate_hold_timer (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [rghold_pkg::CFG_ADDR_W-1:0]    paddr,
	input  wire logic [rghold_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic      [rghold_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                      pready,
	input  wire rghold_pkg::sample_t                  sample,
	input  wire logic                                 sample_valid,
	output logic                                      sample_stall,
	output rghold_pkg::result_t                       result,
	output logic                                      result_valid,
	input  wire logic                                 result_stall
);

	rghold_pkg::sample_t sample_s1;
	logic                valid_s1;
	rghold_pkg::result_t result_q;
	logic                result_valid_q;
	rghold_pkg::result_t core_res;
	logic [31:0]         hold_ms;
	logic                advance;
	logic                fire;

	assign pready = 1'b1;

	rghold_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.hold_ms (hold_ms)
	);

	// The result register moves when it is empty or its word is taken.
	assign advance      = !result_valid_q || !result_stall;
	assign fire         = valid_s1 && advance;
	assign sample_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	rghold_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (sample_s1),
		.hold_ms (hold_ms),
		.res     (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= core_res;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule
`default_nettype wire

// ----- design/rghold_cfg.sv -----
`default_nettype none
module rghold_cfg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [rghold_pkg::CFG_ADDR_W-1:0]    paddr,
	input  wire logic [rghold_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic      [rghold_pkg::CFG_DATA_W-1:0]    prdata,
	output logic      [31:0]                          hold_ms
);

	logic [31:0] hold_q;
	logic [0:0]  reg_idx;

	assign reg_idx = paddr[rghold_pkg::CFG_ADDR_W-1 -: 1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= rghold_pkg::HOLD_RESET;
		end else if (psel && penable && pwrite && reg_idx == rghold_pkg::REG_RECOVERY_HOLD) begin
			hold_q <= pwdata;
		end
	end

	always_comb begin
		case (reg_idx)
			rghold_pkg::REG_RECOVERY_HOLD: prdata = hold_q;
			default:                       prdata = '0;
		endcase
	end

	assign hold_ms = hold_q;

endmodule
`default_nettype wire

// ----- design/rghold_core.sv -----
`default_nettype none
module rghold_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire rghold_pkg::sample_t item,
	input  wire logic [31:0]         hold_ms,
	output rghold_pkg::result_t      res
);

	logic                          seen_q;
	logic [rghold_pkg::TIME_W-1:0] last_time_q;
	logic                          hold_active_q;
	logic [rghold_pkg::TIME_W-1:0] hold_start_q;
	logic                          ever_ready_q;
	logic                          ready_q;
	logic [3:0]                    reason_q;
	logic [rghold_pkg::TIME_W-1:0] change_time_q;
	logic                          snap_q;

	rghold_pkg::reason_t           unsafe;
	rghold_pkg::status_t           status;
	logic                          ok;
	logic                          acc_d;
	logic [3:0]                    reason_d;
	logic                          hold_active_d;
	logic [rghold_pkg::TIME_W-1:0] hold_start_d;
	logic                          ever_ready_d;
	logic [rghold_pkg::TIME_W-1:0] change_time_d;
	logic [rghold_pkg::TIME_W-1:0] elapsed;

	assign unsafe  = rghold_pkg::find_unsafe(item, ever_ready_q, ready_q);
	assign elapsed = item.now_ms - hold_start_q;

	always_comb begin
		if (hold_ms == '0) begin
			status = rghold_pkg::ST_CFG_INVALID;
		end else if (seen_q && item.now_ms < last_time_q) begin
			status = rghold_pkg::ST_CLOCK_REGRESSED;
		end else begin
			status = rghold_pkg::ST_OK;
		end
		ok = (status == rghold_pkg::ST_OK);

		hold_active_d = hold_active_q;
		hold_start_d  = hold_start_q;
		ever_ready_d  = ever_ready_q;
		acc_d         = 1'b0;
		reason_d      = rghold_pkg::R_HOLD;
		if (unsafe != rghold_pkg::R_READY) begin
			hold_active_d = 1'b0;
			reason_d      = unsafe;
		end else if (ready_q) begin
			acc_d    = 1'b1;
			reason_d = rghold_pkg::R_READY;
		end else if (!hold_active_q) begin
			// First safe sample after an unsafe stretch starts the hold.
			hold_active_d = 1'b1;
			hold_start_d  = item.now_ms;
		end else if (elapsed >= {32'd0, hold_ms}) begin
			ever_ready_d  = 1'b1;
			hold_active_d = 1'b0;
			acc_d         = 1'b1;
			reason_d      = rghold_pkg::R_READY;
		end

		// The first good sample always stamps the change time.
		if (!snap_q || ready_q != acc_d || reason_q != reason_d) begin
			change_time_d = item.now_ms;
		end else begin
			change_time_d = change_time_q;
		end

		res.status = status;
		if (ok) begin
			res.accepting   = acc_d;
			res.reason_code = reason_d;
			res.changed_ms  = change_time_d;
		end else begin
			res.accepting   = 1'b0;
			res.reason_code = '0;
			res.changed_ms  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q        <= 1'b0;
			last_time_q   <= '0;
			hold_active_q <= 1'b0;
			hold_start_q  <= '0;
			ever_ready_q  <= 1'b0;
			ready_q       <= 1'b0;
			reason_q      <= rghold_pkg::R_NO_OBSERVATION;
			change_time_q <= '0;
			snap_q        <= 1'b0;
		end else if (fire && ok) begin
			seen_q        <= 1'b1;
			last_time_q   <= item.now_ms;
			hold_active_q <= hold_active_d;
			hold_start_q  <= hold_start_d;
			ever_ready_q  <= ever_ready_d;
			ready_q       <= acc_d;
			reason_q      <= reason_d;
			change_time_q <= change_time_d;
			snap_q        <= 1'b1;
		end
	end

	a_ready_after_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> ever_ready_q)
		else $error("ready without a completed recovery hold");

	a_hold_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		hold_active_q |-> (!ready_q && reason_q == rghold_pkg::R_HOLD))
		else $error("recovery hold running while ready or with another reason");

	a_error_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !ok) |=> ($stable(ready_q) && $stable(reason_q) && $stable(change_time_q)
			&& $stable(last_time_q)))
		else $error("state changed on an error word");

	a_ready_reason: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> reason_q == rghold_pkg::R_READY)
		else $error("ready with a nonzero reason");

endmodule
`default_nettype wire
